FILE: src/abrf_pkg.sv
// Shared types, constants and address mapping for the banked register file.
package abrf_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned DEPTH = 37;
   localparam int unsigned ADDR_W = $clog2(DEPTH);

   // Storage layout of the register memory.
   localparam logic [ADDR_W-1:0] FIQ_BASE  = ADDR_W'(13);
   localparam logic [ADDR_W-1:0] SP_BASE   = ADDR_W'(18);
   localparam logic [ADDR_W-1:0] LR_BASE   = ADDR_W'(24);
   localparam logic [ADDR_W-1:0] PC_ADDR   = ADDR_W'(30);
   localparam logic [ADDR_W-1:0] SPSR_BASE = ADDR_W'(31);

   localparam logic [3:0] FIQ_FIRST = 4'd8;
   localparam logic [3:0] REG_SP = 4'd13;
   localparam logic [3:0] REG_LR = 4'd14;
   localparam logic [3:0] REG_PC = 4'd15;

   localparam logic [DATA_W-1:0] PC_RESET = 32'h0000_0008;
   localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_00D3;

   localparam logic [4:0] MODE_USR = 5'h10;
   localparam logic [4:0] MODE_FIQ = 5'h11;
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_UND = 5'h1B;
   localparam logic [4:0] MODE_SYS = 5'h1F;

   localparam logic [2:0] BANK_FIQ = 3'd1;

   typedef enum logic [2:0] {
      KIND_READ_REG   = 3'd0,
      KIND_WRITE_REG  = 3'd1,
      KIND_READ_SPSR  = 3'd2,
      KIND_WRITE_SPSR = 3'd3,
      KIND_READ_CPSR  = 3'd4,
      KIND_WRITE_CPSR = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       ok;
      logic [2:0] bank;
   } bank_type;

   // Control carried from the accept cycle to the lookup cycle.
   typedef struct packed {
      logic src_ram;
      logic src_cpsr;
      logic bad;
      logic entry_valid;
      logic is_pc;
   } pend_type;

   function automatic bank_type bank_of(input logic [4:0] m);
      bank_type b;
      b.ok = 1'b1;
      unique case (m)
         MODE_USR: b.bank = 3'd0;
         MODE_FIQ: b.bank = 3'd1;
         MODE_IRQ: b.bank = 3'd2;
         MODE_SVC: b.bank = 3'd3;
         MODE_ABT: b.bank = 3'd4;
         MODE_UND: b.bank = 3'd5;
         MODE_SYS: b.bank = 3'd0;
         default: begin
            b.ok = 1'b0;
            b.bank = 3'd0;
         end
      endcase
      return b;
   endfunction

   function automatic logic [ADDR_W-1:0] reg_addr(input logic [3:0] r,
                                                  input logic [2:0] bank);
      logic [ADDR_W-1:0] a;
      priority if (r == REG_PC) begin
         a = PC_ADDR;
      end else if (r == REG_LR) begin
         a = LR_BASE + ADDR_W'(bank);
      end else if (r == REG_SP) begin
         a = SP_BASE + ADDR_W'(bank);
      end else if (bank == BANK_FIQ && r >= FIQ_FIRST) begin
         a = FIQ_BASE + ADDR_W'(r - FIQ_FIRST);
      end else begin
         a = ADDR_W'(r);
      end
      return a;
   endfunction

endpackage

FILE: src/abrf_ram.sv
// Generic single-port RAM with registered read.
module abrf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/arm_banked_register_file_top.sv
// Top level of the mode-banked register file.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | kind, reg_index, mode, use_current_mode,
//           |           |                       | write_value
//   rsp     | out       | rsp_valid / rsp_stall | read_data, invalid_mode
//
// An accepted beat is looked up through the registered read of the register memory, then its
// result is registered in the output register, from which it is taken. The next request beat
// is taken in the cycle its predecessor's result is taken, so the block holds one beat at a time.
// Reset sets the status word to 0xD3 and clears the per-entry valid bits; an entry never
// written reads as zero (R15 as 8). No clearing pass. A stalled result holds the block.
module arm_banked_register_file_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [3:0]  req_reg_index,
   input  logic [4:0]  req_mode,
   input  logic        req_use_current_mode,
   input  logic [31:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_invalid_mode
);

   abrf_pkg::state_type state_ff, state_in;
   logic [abrf_pkg::DATA_W-1:0] cpsr_ff, cpsr_in;
   logic [abrf_pkg::DEPTH-1:0]  valid_ff, valid_in;
   abrf_pkg::pend_type pend_ff, pend_in;
   logic [abrf_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_bad_ff, rsp_bad_in;

   logic accept;
   logic [4:0] mode_sel;
   abrf_pkg::bank_type bank;
   logic [abrf_pkg::ADDR_W-1:0] addr;
   logic ram_wr, ram_rd, cpsr_wr;
   logic [abrf_pkg::DATA_W-1:0] ram_rd_data;

   assign accept = req_valid && !req_stall;
   assign mode_sel = req_use_current_mode ? cpsr_ff[4:0] : req_mode;
   assign bank = abrf_pkg::bank_of(mode_sel);

   // Decode of the accepted beat.
   always_comb begin
      addr = abrf_pkg::reg_addr(req_reg_index, bank.bank);
      ram_wr = 1'b0;
      ram_rd = 1'b0;
      cpsr_wr = 1'b0;
      pend_in = '0;
      unique case (req_kind)
         abrf_pkg::KIND_READ_REG: begin
            ram_rd = accept && bank.ok;
            pend_in.src_ram = bank.ok;
            pend_in.bad = !bank.ok;
         end
         abrf_pkg::KIND_WRITE_REG: begin
            ram_wr = accept && bank.ok;
            pend_in.bad = !bank.ok;
         end
         abrf_pkg::KIND_READ_SPSR: begin
            addr = abrf_pkg::SPSR_BASE + abrf_pkg::ADDR_W'(bank.bank);
            ram_rd = accept && bank.ok;
            pend_in.src_ram = bank.ok;
            pend_in.bad = !bank.ok;
         end
         abrf_pkg::KIND_WRITE_SPSR: begin
            addr = abrf_pkg::SPSR_BASE + abrf_pkg::ADDR_W'(bank.bank);
            ram_wr = accept && bank.ok;
            pend_in.bad = !bank.ok;
         end
         abrf_pkg::KIND_READ_CPSR: begin
            pend_in.src_cpsr = 1'b1;
         end
         abrf_pkg::KIND_WRITE_CPSR: begin
            cpsr_wr = accept;
         end
         default: begin
         end
      endcase
      pend_in.entry_valid = valid_ff[addr];
      pend_in.is_pc = (addr == abrf_pkg::PC_ADDR);
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr) begin
         valid_in[addr] = 1'b1;
      end
      cpsr_in = cpsr_wr ? req_write_value : cpsr_ff;
   end

   // Result formed in the lookup cycle.
   always_comb begin
      rsp_bad_in = pend_ff.bad;
      priority if (pend_ff.src_ram && pend_ff.entry_valid) begin
         rsp_data_in = ram_rd_data;
      end else if (pend_ff.src_ram && pend_ff.is_pc) begin
         rsp_data_in = abrf_pkg::PC_RESET;
      end else if (pend_ff.src_cpsr) begin
         rsp_data_in = cpsr_ff;
      end else begin
         rsp_data_in = '0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         abrf_pkg::ST_IDLE: begin
            if (accept) state_in = abrf_pkg::ST_LOOKUP;
         end
         abrf_pkg::ST_LOOKUP: begin
            state_in = abrf_pkg::ST_RESP;
         end
         abrf_pkg::ST_RESP: begin
            if (!rsp_stall) state_in = accept ? abrf_pkg::ST_LOOKUP : abrf_pkg::ST_IDLE;
         end
         default: state_in = abrf_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall = (state_ff == abrf_pkg::ST_LOOKUP) ||
                  (state_ff == abrf_pkg::ST_RESP && rsp_stall);
      rsp_valid = (state_ff == abrf_pkg::ST_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abrf_pkg::ST_IDLE;
         cpsr_ff <= abrf_pkg::STATUS_RESET;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         cpsr_ff <= cpsr_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (state_ff == abrf_pkg::ST_LOOKUP) begin
         rsp_data_ff <= rsp_data_in;
         rsp_bad_ff <= rsp_bad_in;
      end
   end

   abrf_ram #(
      .WIDTH(abrf_pkg::DATA_W),
      .DEPTH(abrf_pkg::DEPTH)
   ) u_regs (
      .clock  (clock),
      .wr_en  (ram_wr),
      .rd_en  (ram_rd),
      .addr   (addr),
      .wr_data(req_write_value),
      .rd_data(ram_rd_data)
   );

   assign rsp_read_data = rsp_data_ff;
   assign rsp_invalid_mode = rsp_bad_ff;

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == abrf_pkg::ST_LOOKUP)
      else $error("accepted beat did not enter lookup");

   a_lookup_to_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == abrf_pkg::ST_LOOKUP |=> rsp_valid)
      else $error("lookup not followed by a result");

   a_bad_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid_mode |-> rsp_read_data == '0)
      else $error("invalid mode result carries data");

   a_no_accept_in_lookup: assert property (@(posedge clock) disable iff (reset)
      state_ff == abrf_pkg::ST_LOOKUP |-> !accept)
      else $error("beat accepted during lookup");

endmodule

FILE: dv/arm_banked_register_file_top_test.sv
// Self-checking testbench for the mode-banked register file top level.
`timescale 1ns / 100ps

module arm_banked_register_file_top_test;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int TAIL_CYCLES = 8;
   localparam int SEGMENT_ITEMS = 50;
   localparam int MIXED_SEGMENTS = 22;
   localparam int CALM_SEGMENTS = 3;

   // Layout of the predictor's general register cells.
   localparam int PC_AT = 0;
   localparam int SHARED_AT = 1;
   localparam int FIQ_AT = 14;
   localparam int SP_AT = 19;
   localparam int LR_AT = 25;
   localparam int CELL_COUNT = 31;

   typedef struct packed {
      abrf_pkg::kind_type kind;
      logic [3:0]  reg_index;
      logic [4:0]  mode;
      logic        use_cur;
      logic [31:0] value;
   } access_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        invalid_mode;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [3:0]  req_reg_index = '0;
   logic [4:0]  req_mode = '0;
   logic        req_use_current_mode = 1'b0;
   logic [31:0] req_write_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_invalid_mode;

   arm_banked_register_file_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_reg_index(req_reg_index),
      .req_mode(req_mode),
      .req_use_current_mode(req_use_current_mode),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_invalid_mode(rsp_invalid_mode)
   );

   always #5 clock = ~clock;

   access_type pending_accesses[$];
   result_type readback_queue[$];

   logic [31:0] reg_cells [CELL_COUNT];
   logic [31:0] spsr_bank [6];
   logic [31:0] cpsr_value;

   logic sender_idling_on = 1'b0;
   logic receiver_idling_on = 1'b0;
   logic hold_toggle = 1'b0;
   logic hold_seen;
   int   sender_gap;
   int   stall_left;
   int   hold_left;
   int   quiet_cycles;
   int   results_seen = 0;
   int   mismatch_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
      mismatch_count++;
   endtask

   function automatic int mode_bank(input logic [4:0] m);
      case (m)
         abrf_pkg::MODE_USR, abrf_pkg::MODE_SYS: return 0;
         abrf_pkg::MODE_FIQ: return 1;
         abrf_pkg::MODE_IRQ: return 2;
         abrf_pkg::MODE_SVC: return 3;
         abrf_pkg::MODE_ABT: return 4;
         abrf_pkg::MODE_UND: return 5;
         default: return -1;
      endcase
   endfunction

   function automatic int cell_of(input logic [3:0] r, input int bank);
      if (r == abrf_pkg::REG_PC) return PC_AT;
      if (r == abrf_pkg::REG_LR) return LR_AT + bank;
      if (r == abrf_pkg::REG_SP) return SP_AT + bank;
      if (bank == 1 && r >= abrf_pkg::FIQ_FIRST) return FIQ_AT + int'(r - abrf_pkg::FIQ_FIRST);
      return SHARED_AT + int'(r);
   endfunction

   // Applies one access to the predicted register state and returns its result.
   function automatic result_type perform_access(input access_type a);
      result_type res;
      logic [4:0] m;
      int         bank;
      res = '0;
      m = a.use_cur ? cpsr_value[4:0] : a.mode;
      bank = mode_bank(m);
      case (a.kind)
         abrf_pkg::KIND_READ_REG, abrf_pkg::KIND_WRITE_REG,
         abrf_pkg::KIND_READ_SPSR, abrf_pkg::KIND_WRITE_SPSR: begin
            if (bank < 0) begin
               res.invalid_mode = 1'b1;
            end else if (a.kind == abrf_pkg::KIND_READ_REG) begin
               res.read_data = reg_cells[cell_of(a.reg_index, bank)];
            end else if (a.kind == abrf_pkg::KIND_WRITE_REG) begin
               reg_cells[cell_of(a.reg_index, bank)] = a.value;
            end else if (a.kind == abrf_pkg::KIND_READ_SPSR) begin
               res.read_data = spsr_bank[bank];
            end else begin
               spsr_bank[bank] = a.value;
            end
         end
         abrf_pkg::KIND_READ_CPSR: res.read_data = cpsr_value;
         abrf_pkg::KIND_WRITE_CPSR: cpsr_value = a.value;
         default: ;
      endcase
      return res;
   endfunction

   function automatic access_type make_access(input abrf_pkg::kind_type k,
                                              input logic [3:0] r,
                                              input logic [4:0] m, input logic cur,
                                              input logic [31:0] v);
      access_type a;
      a.kind = k;
      a.reg_index = r;
      a.mode = m;
      a.use_cur = cur;
      a.value = v;
      return a;
   endfunction

   function automatic logic [4:0] listed_mode();
      case ($urandom_range(0, 6))
         0: return abrf_pkg::MODE_USR;
         1: return abrf_pkg::MODE_FIQ;
         2: return abrf_pkg::MODE_IRQ;
         3: return abrf_pkg::MODE_SVC;
         4: return abrf_pkg::MODE_ABT;
         5: return abrf_pkg::MODE_UND;
         default: return abrf_pkg::MODE_SYS;
      endcase
   endfunction

   function automatic access_type random_access();
      access_type a;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) a.kind = abrf_pkg::KIND_READ_REG;
      else if (pick < 60) a.kind = abrf_pkg::KIND_WRITE_REG;
      else if (pick < 70) a.kind = abrf_pkg::KIND_READ_SPSR;
      else if (pick < 80) a.kind = abrf_pkg::KIND_WRITE_SPSR;
      else if (pick < 90) a.kind = abrf_pkg::KIND_READ_CPSR;
      else a.kind = abrf_pkg::KIND_WRITE_CPSR;
      a.reg_index = 4'($urandom_range(0, 15));
      a.mode = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31)) : listed_mode();
      a.use_cur = ($urandom_range(0, 2) == 0);
      a.value = $urandom();
      // keep the current mode mostly valid so use_current_mode reaches the banks
      if (a.kind == abrf_pkg::KIND_WRITE_CPSR && $urandom_range(0, 9) != 0)
         a.value[4:0] = listed_mode();
      return a;
   endfunction

   // Request driver: holds a beat until it is taken, then loads the next or idles.
   always @(posedge clock) begin : drive_requests
      access_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         sender_gap <= 0;
      end else begin
         if (req_valid && !req_stall)
            readback_queue.push_back(perform_access(make_access(
               abrf_pkg::kind_type'(req_kind), req_reg_index, req_mode,
               req_use_current_mode, req_write_value)));
         if (!req_valid || !req_stall) begin
            if (sender_gap != 0) begin
               sender_gap <= sender_gap - 1;
               req_valid <= 1'b0;
            end else if (sender_idling_on && $urandom_range(0, 5) == 0) begin
               sender_gap <= $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else if (pending_accesses.size() != 0) begin
               nxt = pending_accesses.pop_front();
               req_kind <= nxt.kind;
               req_reg_index <= nxt.reg_index;
               req_mode <= nxt.mode;
               req_use_current_mode <= nxt.use_cur;
               req_write_value <= nxt.value;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stall generator.
   always @(posedge clock) begin : check_results
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_seen <= hold_toggle;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (readback_queue.size() == 0) begin
               report_mismatch("beat with nothing pending", rsp_read_data, '0);
            end else begin
               want = readback_queue.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_invalid_mode !== want.invalid_mode)
                  report_mismatch("invalid_mode", 32'(rsp_invalid_mode),
                                  32'(want.invalid_mode));
            end
            results_seen++;
         end
         if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_OFF_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (receiver_idling_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("no beat for %0d cycles", QUIET_LIMIT);
         $display("** arm_banked_register_file_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_phases
      foreach (reg_cells[i]) reg_cells[i] = '0;
      foreach (spsr_bank[i]) spsr_bank[i] = '0;
      reg_cells[PC_AT] = abrf_pkg::PC_RESET;
      cpsr_value = abrf_pkg::STATUS_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values, FIQ banking, shared bank 0, invalid modes, current-mode switch
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, abrf_pkg::REG_PC,
                                             abrf_pkg::MODE_SVC, 1'b1, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_CPSR, abrf_pkg::REG_PC,
                                             5'h00, 1'b1, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_REG, 4'd8,
                                             abrf_pkg::MODE_FIQ, 1'b0, '1));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_REG, 4'd8,
                                             abrf_pkg::MODE_USR, 1'b0, 32'h1));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, 4'd8,
                                             abrf_pkg::MODE_FIQ, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, 4'd8,
                                             abrf_pkg::MODE_SYS, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_REG, 4'd12,
                                             abrf_pkg::MODE_FIQ, 1'b0, 32'hA5A5_A5A5));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, 4'd12,
                                             abrf_pkg::MODE_IRQ, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_REG, abrf_pkg::REG_LR,
                                             abrf_pkg::MODE_UND, 1'b0, '1));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, abrf_pkg::REG_LR,
                                             abrf_pkg::MODE_ABT, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, abrf_pkg::REG_LR,
                                             abrf_pkg::MODE_UND, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_REG, abrf_pkg::REG_SP,
                                             abrf_pkg::MODE_SYS, 1'b0, 32'h5A5A_5A5A));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_SPSR, 4'd0,
                                             abrf_pkg::MODE_USR, 1'b0, '1));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_SPSR, 4'd0,
                                             abrf_pkg::MODE_SYS, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, 4'd3, 5'h00, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_REG, 4'd3, 5'h1E, 1'b0, '1));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_SPSR, 4'd0, 5'h14, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_SPSR, 4'd0, 5'h15, 1'b0, '1));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_REG, abrf_pkg::REG_PC,
                                             abrf_pkg::MODE_IRQ, 1'b0, '1));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, abrf_pkg::REG_PC,
                                             abrf_pkg::MODE_ABT, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_CPSR, 4'd0, 5'h00, 1'b0,
                                             32'h0000_0011));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, 4'd8,
                                             abrf_pkg::MODE_USR, 1'b1, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_CPSR, 4'd0, 5'h00, 1'b0,
                                             32'hFFFF_FFE0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_REG, 4'd0,
                                             abrf_pkg::MODE_USR, 1'b1, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_READ_CPSR, 4'd0, 5'h1F, 1'b0, '0));
      pending_accesses.push_back(make_access(abrf_pkg::KIND_WRITE_CPSR, 4'd0, 5'h00, 1'b0,
                                             abrf_pkg::STATUS_RESET));

      while (pending_accesses.size() != 0 || req_valid || readback_queue.size() != 0)
         @(negedge clock);

      for (int seg = 0; seg < MIXED_SEGMENTS; seg++) begin
         while (pending_accesses.size() > 8) @(negedge clock);
         sender_idling_on = ($urandom_range(0, 2) != 0);
         receiver_idling_on = ($urandom_range(0, 2) != 0);
         // long receiver hold-off while the sender keeps offering beats
         if (seg == 6) begin
            sender_idling_on = 1'b0;
            hold_toggle = ~hold_toggle;
         end
         repeat (SEGMENT_ITEMS) pending_accesses.push_back(random_access());
      end

      // sender pause: let every outstanding result come back
      while (pending_accesses.size() != 0 || req_valid || readback_queue.size() != 0)
         @(negedge clock);

      sender_idling_on = 1'b0;
      receiver_idling_on = 1'b0;
      repeat (CALM_SEGMENTS * SEGMENT_ITEMS) pending_accesses.push_back(random_access());

      while (pending_accesses.size() != 0 || req_valid || readback_queue.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (readback_queue.size() != 0)
         report_mismatch("results never returned", 32'(readback_queue.size()), '0);

      if (mismatch_count == 0) begin
         $display("** arm_banked_register_file_top: PASSED **");
      end else begin
         $display("** arm_banked_register_file_top: FAILED **");
      end
      $finish;
   end

endmodule
